[src/opt_pkg.sv]
// Shared types and constants for the order position tracker.
// Used by opt_ctrl, opt_dp and order_position_tracker; depends on nothing.
`default_nettype none

package opt_pkg;

    // Event kinds.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_FILL   = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;
    localparam logic [1:0] FUNC_ERROR  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;

    localparam logic [1:0] OFFSET_OPEN   = 2'd0;
    localparam logic       SIDE_LONG     = 1'b0;
    localparam logic       ERR_INSERT    = 1'b0;

    localparam int ID_W  = 10;
    localparam int QTY_W = 24;

    typedef struct packed {
        logic [1:0]       func;
        logic [ID_W-1:0]  order_id;
        logic [5:0]       symbol_index;
        logic             side;
        logic [1:0]       open_close;
        logic [QTY_W-1:0] quantity;
        logic             error_kind;
    } req_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    assigned_id;
        logic [1:0]         status;
        logic signed [31:0] long_held;
        logic signed [31:0] long_pending;
        logic signed [31:0] long_frozen;
        logic signed [31:0] short_held;
        logic signed [31:0] short_pending;
        logic signed [31:0] short_frozen;
        logic signed [31:0] order_remaining;
        logic signed [31:0] order_filled;
        logic signed [31:0] order_cancelled;
    } rsp_item_t;

    typedef struct packed {
        logic signed [31:0] long_held;
        logic signed [31:0] long_pending;
        logic signed [31:0] long_frozen;
        logic signed [31:0] short_held;
        logic signed [31:0] short_pending;
        logic signed [31:0] short_frozen;
    } pos_entry_t;

    typedef struct packed {
        logic signed [31:0] remaining;
        logic signed [31:0] filled;
        logic signed [31:0] cancelled;
    } ord_vol_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic pos_rd;
        logic calc;
        logic commit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } dp_stat_t;

    // Adds a small signed delta to a 32-bit count, clamping to the signed range.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [25:0] d);
        logic signed [33:0] s;
        s = {{2{a[31]}}, a} + {{8{d[25]}}, d};
        if (s[33:31] == 3'b000 || s[33:31] == 3'b111)
            sat_add = s[31:0];
        else if (s[33])
            sat_add = 32'sh8000_0000;
        else
            sat_add = 32'sh7FFF_FFFF;
    endfunction

endpackage

`default_nettype wire

[src/opt_ctrl.sv]
// Sequencing state machine for the order position tracker.
// Depends on opt_pkg for the command and status structs.
`default_nettype none

module opt_ctrl import opt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RDPOS = 5'b00100,
        ST_CALC  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RDPOS;
                end
            end
            ST_RDPOS:
            begin
                cmd.pos_rd = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // The result register must be free before the item is committed.
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[src/opt_dp.sv]
// Datapath of the order position tracker: order and position memories,
// saturating update logic and the result register. Depends on opt_pkg.
`default_nettype none

module opt_dp import opt_pkg::*;
#(
    parameter int MAX_ORDERS  = 1024,
    parameter int MAX_SYMBOLS = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_item_t req,
    input  wire ctl_cmd_t  cmd,
    output dp_stat_t       stat,
    output rsp_item_t      rsp,
    output logic           rsp_valid,
    input  wire logic      rsp_ready
);

    localparam int OIDX_W = $clog2(MAX_ORDERS);
    localparam int CNT_W  = $clog2(MAX_ORDERS + 1);
    localparam int SYM_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int WIDE_W = (CNT_W > ID_W) ? CNT_W : ID_W;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             side;
        logic             open;
        logic [QTY_W-1:0] volume;
    } ord_req_t;

    // Memories.
    ord_req_t   req_mem [MAX_ORDERS];
    ord_vol_t   vol_mem [MAX_ORDERS];
    pos_entry_t pos_mem [MAX_SYMBOLS];

    // Symbol slot reduction, worked out at elaboration.
    logic [SYM_W-1:0] sym_lut [64];
    for (genvar i = 0; i < 64; i++)
    begin : g_sym_lut
        assign sym_lut[i] = SYM_W'(i % MAX_SYMBOLS);
    end

    logic [CNT_W-1:0]  count_reg;
    logic [SYM_W-1:0]  clr_cnt_reg;
    logic              rsp_valid_reg;

    req_item_t         item_reg;
    logic [1:0]        status_reg;
    logic [ID_W-1:0]   id_reg;
    logic [OIDX_W-1:0] ord_addr_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic [SYM_W-1:0]  pos_addr_reg;
    ord_req_t          req_rd_reg;
    ord_vol_t          vol_rd_reg;
    pos_entry_t        pos_rd_reg;
    pos_entry_t        new_pos_reg;
    ord_vol_t          new_vol_reg;
    rsp_item_t         rsp_reg;

    logic [WIDE_W-1:0] oid_wide;
    logic [WIDE_W-1:0] cnt_wide;
    logic              is_insert;
    logic              full;
    logic              unknown;
    logic [1:0]        status_next;
    logic [ID_W-1:0]   id_next;
    logic [OIDX_W-1:0] ord_addr_next;
    logic [SYM_W-1:0]  pos_addr_next;
    logic              ok_commit;

    assign oid_wide  = WIDE_W'(req.order_id);
    assign cnt_wide  = WIDE_W'(count_reg);
    assign is_insert = (req.func == FUNC_INSERT);
    assign full      = (count_reg == CNT_W'(MAX_ORDERS));
    assign unknown   = (oid_wide >= cnt_wide);

    always_comb
    begin
        if (is_insert)
        begin
            ord_addr_next = count_reg[OIDX_W-1:0];
            status_next   = full ? STAT_FULL : STAT_OK;
            id_next       = full ? '0 : cnt_wide[ID_W-1:0];
        end
        else
        begin
            ord_addr_next = oid_wide[OIDX_W-1:0];
            status_next   = unknown ? STAT_UNKNOWN : STAT_OK;
            id_next       = req.order_id;
        end
    end

    // Capture of the item and the order-table read.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg     <= req;
            status_reg   <= status_next;
            id_reg       <= id_next;
            ord_addr_reg <= ord_addr_next;
            sym_reg      <= sym_lut[req.symbol_index];
            req_rd_reg   <= req_mem[oid_wide[OIDX_W-1:0]];
            vol_rd_reg   <= vol_mem[oid_wide[OIDX_W-1:0]];
        end
    end

    // An insert names its symbol directly; other events find it in the order entry.
    assign pos_addr_next = (item_reg.func == FUNC_INSERT) ? sym_reg : req_rd_reg.sym;

    always_ff @(posedge clk)
    begin
        if (cmd.pos_rd)
        begin
            pos_addr_reg <= pos_addr_next;
            pos_rd_reg   <= pos_mem[pos_addr_next];
        end
    end

    // Update arithmetic.
    ord_req_t           new_req;
    logic               open;
    logic               sd;
    logic signed [25:0] q;
    logic signed [25:0] vol;
    logic signed [25:0] d_ctr;
    logic signed [25:0] d_held;
    logic signed [25:0] d_lh, d_lp, d_lf, d_sh, d_sp, d_sf;
    pos_entry_t         new_pos;
    ord_vol_t           new_vol;

    always_comb
    begin
        new_req.sym    = sym_reg;
        new_req.side   = item_reg.side;
        new_req.open   = (item_reg.open_close == OFFSET_OPEN);
        new_req.volume = item_reg.quantity;

        open = (item_reg.func == FUNC_INSERT) ? new_req.open : req_rd_reg.open;
        sd   = ((item_reg.func == FUNC_INSERT) ? item_reg.side : req_rd_reg.side) ^ ~open;
        q    = {2'b00, item_reg.quantity};
        vol  = {2'b00, req_rd_reg.volume};

        unique case (item_reg.func)
            FUNC_INSERT: d_ctr = q;
            FUNC_FILL:   d_ctr = -q;
            FUNC_CANCEL: d_ctr = -q;
            default:     d_ctr = (item_reg.error_kind == ERR_INSERT) ? -vol : '0;
        endcase
        d_held = (item_reg.func == FUNC_FILL) ? (open ? q : -q) : '0;

        d_lh = (sd == SIDE_LONG) ? d_held : '0;
        d_sh = (sd != SIDE_LONG) ? d_held : '0;
        d_lp = (sd == SIDE_LONG && open)  ? d_ctr : '0;
        d_lf = (sd == SIDE_LONG && !open) ? d_ctr : '0;
        d_sp = (sd != SIDE_LONG && open)  ? d_ctr : '0;
        d_sf = (sd != SIDE_LONG && !open) ? d_ctr : '0;

        new_pos.long_held     = sat_add(pos_rd_reg.long_held, d_lh);
        new_pos.long_pending  = sat_add(pos_rd_reg.long_pending, d_lp);
        new_pos.long_frozen   = sat_add(pos_rd_reg.long_frozen, d_lf);
        new_pos.short_held    = sat_add(pos_rd_reg.short_held, d_sh);
        new_pos.short_pending = sat_add(pos_rd_reg.short_pending, d_sp);
        new_pos.short_frozen  = sat_add(pos_rd_reg.short_frozen, d_sf);

        unique case (item_reg.func)
            FUNC_INSERT:
            begin
                new_vol.remaining = 32'(signed'(q));
                new_vol.filled    = '0;
                new_vol.cancelled = '0;
            end
            FUNC_FILL:
            begin
                new_vol.remaining = sat_add(vol_rd_reg.remaining, -q);
                new_vol.filled    = sat_add(vol_rd_reg.filled, q);
                new_vol.cancelled = vol_rd_reg.cancelled;
            end
            FUNC_CANCEL:
            begin
                new_vol.remaining = sat_add(vol_rd_reg.remaining, -q);
                new_vol.filled    = vol_rd_reg.filled;
                new_vol.cancelled = sat_add(vol_rd_reg.cancelled, q);
            end
            default:
            begin
                new_vol = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            new_pos_reg <= new_pos;
            new_vol_reg <= new_vol;
        end
    end

    // Write-back of the order entry and the position entry.
    assign ok_commit = cmd.commit && (status_reg == STAT_OK);

    always_ff @(posedge clk)
    begin
        if (ok_commit)
            vol_mem[ord_addr_reg] <= new_vol_reg;
        if (ok_commit && item_reg.func == FUNC_INSERT)
            req_mem[ord_addr_reg] <= new_req;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            pos_mem[clr_cnt_reg] <= '0;
        else if (ok_commit)
            pos_mem[pos_addr_reg] <= new_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (ok_commit && item_reg.func == FUNC_INSERT)
                count_reg <= count_reg + 1'b1;
        end
    end

    // Result register.
    rsp_item_t rsp_next;

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.assigned_id = id_reg;
        rsp_next.status      = status_reg;
        if (status_reg == STAT_OK)
        begin
            rsp_next.long_held       = new_pos_reg.long_held;
            rsp_next.long_pending    = new_pos_reg.long_pending;
            rsp_next.long_frozen     = new_pos_reg.long_frozen;
            rsp_next.short_held      = new_pos_reg.short_held;
            rsp_next.short_pending   = new_pos_reg.short_pending;
            rsp_next.short_frozen    = new_pos_reg.short_frozen;
            rsp_next.order_remaining = new_vol_reg.remaining;
            rsp_next.order_filled    = new_vol_reg.filled;
            rsp_next.order_cancelled = new_vol_reg.cancelled;
        end
        else if (status_reg == STAT_FULL)
        begin
            // A rejected insert reports the symbol's position as it stands.
            rsp_next.long_held     = pos_rd_reg.long_held;
            rsp_next.long_pending  = pos_rd_reg.long_pending;
            rsp_next.long_frozen   = pos_rd_reg.long_frozen;
            rsp_next.short_held    = pos_rd_reg.short_held;
            rsp_next.short_pending = pos_rd_reg.short_pending;
            rsp_next.short_frozen  = pos_rd_reg.short_frozen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.commit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    assign rsp            = rsp_reg;
    assign rsp_valid      = rsp_valid_reg;
    assign stat.out_busy  = rsp_valid_reg && !rsp_ready;
    assign stat.clr_last  = (clr_cnt_reg == SYM_W'(MAX_SYMBOLS - 1));

endmodule

`default_nettype wire

[src/order_position_tracker.sv]
// Top level of the order position tracker: controller plus datapath.
// Depends on opt_pkg, opt_ctrl and opt_dp.
`default_nettype none

// Tracks orders and per-symbol long/short positions. Each request item is an
// insert, fill, cancel or error event and yields exactly one response item
// with the affected position and order volumes, all sums saturating at
// 32 bits signed. Items are handled one at a time and pass from acceptance
// to the result register through accept with order-table read, position
// read, update and write-back, because the position address of a fill,
// cancel or error comes out of the order-table read. req_ready rises again in
// the cycle after write-back, so no new item is taken before the last one is
// written back, and write-back waits for a free result register. After reset
// the position table is cleared, one symbol per cycle, with req_ready low.
module order_position_tracker import opt_pkg::*;
#(
    parameter int MAX_ORDERS  = 1024,
    parameter int MAX_SYMBOLS = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    opt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    opt_dp #(
        .MAX_ORDERS  (MAX_ORDERS),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

    // Only one item is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another item was in flight");

    // An unknown reference reports an all-zero position and order.
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_UNKNOWN |->
            rsp.long_held == 0 && rsp.long_pending == 0 && rsp.long_frozen == 0 &&
            rsp.short_held == 0 && rsp.short_pending == 0 && rsp.short_frozen == 0 &&
            rsp.order_remaining == 0 && rsp.order_filled == 0 &&
            rsp.order_cancelled == 0)
        else $error("unknown reference reported non-zero volumes");

    // A rejected insert gets reference zero and no order volumes.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |->
            rsp.assigned_id == 0 && rsp.order_remaining == 0 &&
            rsp.order_filled == 0 && rsp.order_cancelled == 0)
        else $error("rejected insert reported an order");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for order_position_tracker: a clocked driver and monitor
// around the block, with a cycle-free model of the order and position tables.
// Depends on opt_pkg and the order_position_tracker RTL only.
`default_nettype none

module testbench;
    import opt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ORDER_SLOTS  = 1024;
    localparam int SYMBOL_SLOTS = 64;
    localparam int MAX_QTY      = 24'hFFFFFF;
    localparam int SAT_RUN      = 136;
    localparam int TAIL_ITEMS   = 40;
    localparam int RANDOM_ITEMS = 170;

    localparam logic       SIDE_SHORT       = ~SIDE_LONG;
    localparam logic       ERR_CANCEL       = ~ERR_INSERT;
    localparam logic [1:0] OFFSET_CLOSE     = 2'd1;
    localparam logic [1:0] OFFSET_CLOSE_TDY = 2'd2;
    localparam logic [1:0] OFFSET_CLOSE_YDY = 2'd3;

    localparam int HELD = 0;
    localparam int PEND = 1;
    localparam int FROZ = 2;

    localparam longint SUM_TOP    = 64'sd2147483647;
    localparam longint SUM_BOTTOM = -64'sd2147483648;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    order_position_tracker #(
        .MAX_ORDERS(ORDER_SLOTS),
        .MAX_SYMBOLS(SYMBOL_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Model state: the order table and the per-symbol position book.
    int       order_total = 0;
    bit [5:0] ord_sym    [ORDER_SLOTS];
    bit       ord_side   [ORDER_SLOTS];
    bit [1:0] ord_offset [ORDER_SLOTS];
    int       ord_qty    [ORDER_SLOTS];
    int       ord_left   [ORDER_SLOTS];
    int       ord_done   [ORDER_SLOTS];
    int       ord_cxl    [ORDER_SLOTS];
    int       pos_book   [SYMBOL_SLOTS][2][3];

    req_item_t event_q[$];
    rsp_item_t outcome_q[$];
    int        pushed_orders = 0;
    int        errors = 0;
    bit        gen_done = 1'b0;

    function automatic int clamp_sum(input int a, input longint d);
        longint s;
        s = longint'(a) + d;
        if (s > SUM_TOP)
            return int'(SUM_TOP);
        if (s < SUM_BOTTOM)
            return int'(SUM_BOTTOM);
        return int'(s);
    endfunction

    // Applies one event to the model and returns the result the block should give.
    function automatic rsp_item_t book_event(input req_item_t ev);
        rsp_item_t r;
        int        id;
        int        sym;
        int        sd;
        int        ctr;
        longint    q;
        bit        show_pos;
        bit        show_ord;
        r = '0;
        id = 0;
        sym = 0;
        show_pos = 1'b0;
        show_ord = 1'b0;
        q = ev.quantity;
        if (ev.func == FUNC_INSERT)
        begin
            sym = ev.symbol_index % SYMBOL_SLOTS;
            show_pos = 1'b1;
            if (order_total >= ORDER_SLOTS)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                id = order_total;
                order_total++;
                ord_sym[id] = sym[5:0];
                ord_side[id] = ev.side;
                ord_offset[id] = ev.open_close;
                ord_qty[id] = int'(q);
                ord_left[id] = int'(q);
                ord_done[id] = 0;
                ord_cxl[id] = 0;
                // An opening order books pending on its own side, a closing one
                // freezes the opposite side.
                sd = (ev.open_close == OFFSET_OPEN) ? ev.side : !ev.side;
                ctr = (ev.open_close == OFFSET_OPEN) ? PEND : FROZ;
                pos_book[sym][sd][ctr] = clamp_sum(pos_book[sym][sd][ctr], q);
                r.assigned_id = id[ID_W-1:0];
                r.status = STAT_OK;
                show_ord = 1'b1;
            end
        end
        else if (ev.order_id >= order_total)
        begin
            r.assigned_id = ev.order_id;
            r.status = STAT_UNKNOWN;
        end
        else
        begin
            id = ev.order_id;
            sym = ord_sym[id];
            sd = (ord_offset[id] == OFFSET_OPEN) ? ord_side[id] : !ord_side[id];
            ctr = (ord_offset[id] == OFFSET_OPEN) ? PEND : FROZ;
            show_pos = 1'b1;
            show_ord = 1'b1;
            r.assigned_id = id[ID_W-1:0];
            r.status = STAT_OK;
            case (ev.func)
                FUNC_FILL:
                begin
                    ord_done[id] = clamp_sum(ord_done[id], q);
                    ord_left[id] = clamp_sum(ord_left[id], -q);
                    pos_book[sym][sd][HELD] = clamp_sum(pos_book[sym][sd][HELD],
                                                        (ctr == PEND) ? q : -q);
                    pos_book[sym][sd][ctr] = clamp_sum(pos_book[sym][sd][ctr], -q);
                end
                FUNC_CANCEL:
                begin
                    ord_left[id] = clamp_sum(ord_left[id], -q);
                    ord_cxl[id] = clamp_sum(ord_cxl[id], q);
                    pos_book[sym][sd][ctr] = clamp_sum(pos_book[sym][sd][ctr], -q);
                end
                default:
                begin
                    ord_left[id] = 0;
                    ord_done[id] = 0;
                    ord_cxl[id] = 0;
                    if (ev.error_kind == ERR_INSERT)
                        pos_book[sym][sd][ctr] = clamp_sum(pos_book[sym][sd][ctr],
                                                           -longint'(ord_qty[id]));
                end
            endcase
        end
        if (show_pos)
        begin
            r.long_held     = pos_book[sym][SIDE_LONG][HELD];
            r.long_pending  = pos_book[sym][SIDE_LONG][PEND];
            r.long_frozen   = pos_book[sym][SIDE_LONG][FROZ];
            r.short_held    = pos_book[sym][SIDE_SHORT][HELD];
            r.short_pending = pos_book[sym][SIDE_SHORT][PEND];
            r.short_frozen  = pos_book[sym][SIDE_SHORT][FROZ];
        end
        if (show_ord)
        begin
            r.order_remaining = ord_left[id];
            r.order_filled    = ord_done[id];
            r.order_cancelled = ord_cxl[id];
        end
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected %0d, actual %0d", $time, what,
                     $signed(want), $signed(got));
            errors++;
        end
    endtask

    // Sender: takes items from the pending queue, with bursts of idling and
    // calm stretches without any.
    int send_gap = 0;
    int send_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap = 0;
            send_calm = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                outcome_q.push_back(book_event(req));
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 99) == 0)
                send_calm = $urandom_range(30, 80);
            if (!req_valid || req_ready)
            begin
                if (send_gap == 0 && send_calm == 0 &&
                    !(gen_done && event_q.size() < TAIL_ITEMS) &&
                    $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 11);
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (event_q.size() > 0)
                begin
                    req <= event_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result item against the oldest expectation.
    int take_gap = 0;
    int take_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            take_gap = 0;
            take_calm = 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual id %0d",
                             $time, rsp.assigned_id);
                    errors++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("assigned_id", want.assigned_id, rsp.assigned_id);
                    check_field("status", want.status, rsp.status);
                    check_field("long_held", want.long_held, rsp.long_held);
                    check_field("long_pending", want.long_pending, rsp.long_pending);
                    check_field("long_frozen", want.long_frozen, rsp.long_frozen);
                    check_field("short_held", want.short_held, rsp.short_held);
                    check_field("short_pending", want.short_pending, rsp.short_pending);
                    check_field("short_frozen", want.short_frozen, rsp.short_frozen);
                    check_field("order_remaining", want.order_remaining,
                                rsp.order_remaining);
                    check_field("order_filled", want.order_filled, rsp.order_filled);
                    check_field("order_cancelled", want.order_cancelled,
                                rsp.order_cancelled);
                end
            end
            if (take_calm > 0)
                take_calm--;
            else if ($urandom_range(0, 99) == 0)
                take_calm = $urandom_range(30, 80);
            if (take_gap == 0 && take_calm == 0 &&
                !(gen_done && event_q.size() < TAIL_ITEMS) &&
                $urandom_range(0, 5) == 0)
                take_gap = $urandom_range(1, 11);
            if (take_gap > 0)
            begin
                take_gap--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    task automatic queue_event(input logic [1:0] fn, input int id, input int sym,
                               input logic sd, input logic [1:0] oc, input int qty,
                               input logic ek);
        req_item_t e;
        e.func = fn;
        e.order_id = id[ID_W-1:0];
        e.symbol_index = sym[5:0];
        e.side = sd;
        e.open_close = oc;
        e.quantity = qty[QTY_W-1:0];
        e.error_kind = ek;
        event_q.push_back(e);
        if (fn == FUNC_INSERT && pushed_orders < ORDER_SLOTS)
            pushed_orders++;
    endtask

    function automatic int pick_qty();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1000);
            1: return MAX_QTY;
            default: return $urandom & MAX_QTY;
        endcase
    endfunction

    // One random item; references mostly name recent orders, now and then one
    // that does not exist yet.
    task automatic queue_random(input int insert_pct);
        logic [1:0] fn;
        int         id;
        int         span;
        id = $urandom_range(0, ORDER_SLOTS - 1);
        if ($urandom_range(0, 99) < insert_pct || pushed_orders == 0)
        begin
            fn = FUNC_INSERT;
        end
        else
        begin
            case ($urandom_range(0, 5))
                0, 1, 2: fn = FUNC_FILL;
                3, 4:    fn = FUNC_CANCEL;
                default: fn = FUNC_ERROR;
            endcase
            span = (pushed_orders > 16) ? 15 : pushed_orders - 1;
            if ($urandom_range(0, 9) == 0)
            begin
                if (pushed_orders < ORDER_SLOTS)
                    id = $urandom_range(pushed_orders, ORDER_SLOTS - 1);
            end
            else if ($urandom_range(0, 2) != 0)
                id = pushed_orders - 1 - $urandom_range(0, span);
            else
                id = $urandom_range(0, pushed_orders - 1);
        end
        queue_event(fn, id, $urandom_range(0, 63), $urandom_range(0, 1),
                    $urandom_range(0, 3), pick_qty(), $urandom_range(0, 1));
    endtask

    task automatic wait_until_settled();
        while (event_q.size() != 0 || req_valid || outcome_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int sym;
        int first;

        // Unknown references before any order exists, then each kind of insert.
        queue_event(FUNC_FILL, 0, 5, SIDE_LONG, OFFSET_OPEN, 10, ERR_INSERT);
        queue_event(FUNC_CANCEL, 1023, 63, SIDE_SHORT, OFFSET_CLOSE_YDY, MAX_QTY,
                    ERR_CANCEL);
        queue_event(FUNC_ERROR, 0, 0, SIDE_LONG, OFFSET_OPEN, 0, ERR_INSERT);
        queue_event(FUNC_INSERT, 1023, 0, SIDE_LONG, OFFSET_OPEN, MAX_QTY, ERR_CANCEL);
        queue_event(FUNC_INSERT, 0, 63, SIDE_SHORT, OFFSET_OPEN, 0, ERR_INSERT);
        queue_event(FUNC_INSERT, 512, 0, SIDE_LONG, OFFSET_CLOSE, 1000, ERR_INSERT);
        queue_event(FUNC_INSERT, 7, 0, SIDE_SHORT, OFFSET_CLOSE_TDY, 500, ERR_CANCEL);
        queue_event(FUNC_INSERT, 300, 63, SIDE_LONG, OFFSET_CLOSE_YDY, MAX_QTY,
                    ERR_INSERT);
        queue_event(FUNC_FILL, 0, 1, SIDE_SHORT, OFFSET_CLOSE, 100, ERR_CANCEL);
        queue_event(FUNC_FILL, 2, 2, SIDE_LONG, OFFSET_OPEN, 300, ERR_INSERT);
        queue_event(FUNC_CANCEL, 0, 3, SIDE_LONG, OFFSET_OPEN, 50, ERR_INSERT);
        queue_event(FUNC_CANCEL, 3, 4, SIDE_SHORT, OFFSET_OPEN, 200, ERR_CANCEL);
        // Cancel error only clears the order; insert error also releases its volume.
        queue_event(FUNC_ERROR, 1, 9, SIDE_LONG, OFFSET_OPEN, 77, ERR_CANCEL);
        queue_event(FUNC_ERROR, 0, 9, SIDE_SHORT, OFFSET_CLOSE, 77, ERR_INSERT);
        queue_event(FUNC_ERROR, 4, 9, SIDE_LONG, OFFSET_OPEN, 0, ERR_INSERT);
        queue_event(FUNC_FILL, 1, 0, SIDE_LONG, OFFSET_OPEN, MAX_QTY, ERR_INSERT);
        queue_event(FUNC_FILL, 5, 0, SIDE_LONG, OFFSET_OPEN, 1, ERR_INSERT);
        queue_event(FUNC_CANCEL, 2, 0, SIDE_LONG, OFFSET_OPEN, MAX_QTY, ERR_INSERT);
        queue_event(FUNC_ERROR, 3, 0, SIDE_LONG, OFFSET_OPEN, 5, ERR_CANCEL);
        queue_event(FUNC_INSERT, 0, 31, SIDE_SHORT, OFFSET_OPEN, MAX_QTY, ERR_INSERT);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Hold the sender back until the directed items have all come back.
        wait_until_settled();

        repeat (RANDOM_ITEMS)
            queue_random(35);

        // Drive one symbol's counts and one order's volumes into both clamps.
        sym = $urandom_range(0, 63);
        first = pushed_orders;
        queue_event(FUNC_INSERT, $urandom, sym, SIDE_LONG, OFFSET_OPEN, MAX_QTY,
                    $urandom_range(0, 1));
        queue_event(FUNC_INSERT, $urandom, sym, SIDE_SHORT, OFFSET_CLOSE, MAX_QTY,
                    $urandom_range(0, 1));
        repeat (SAT_RUN)
            queue_event(FUNC_INSERT, $urandom, sym, SIDE_LONG, OFFSET_OPEN, MAX_QTY,
                        $urandom_range(0, 1));
        repeat (SAT_RUN)
            queue_event(FUNC_FILL, first + 1, $urandom, $urandom_range(0, 1),
                        $urandom_range(0, 3), MAX_QTY, $urandom_range(0, 1));
        wait_until_settled();

        repeat (TAIL_ITEMS)
            queue_random(10);
        gen_done = 1'b1;

        wait_until_settled();
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/opt_pkg.sv
src/opt_ctrl.sv
src/opt_dp.sv
src/order_position_tracker.sv
dv/testbench.sv
